FILE: hdl/region_handle_lru_cache_unit_defines.svh
// Assertion macros for the region handle cache port checker.
`ifndef REGION_HANDLE_LRU_CACHE_UNIT_DEFINES_SVH
`define REGION_HANDLE_LRU_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RHLC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RHLC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rhlc_pkg.sv
// Package of shared constants and types for the region handle LRU cache.
`default_nettype none
package rhlc_pkg;

   localparam int DEF_WAYS         = 8;
   localparam int DEF_REGION_SHIFT = 5;
   localparam int CHUNK_W          = 24;
   localparam int EV_W             = 19;
   localparam int SLOT_W           = 3;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_CMP  = 3'b010,
      PH_UPD  = 3'b100
   } phase_type;

   // Broadcast update strobes from the controller to every cell.
   typedef struct packed {
      logic upd;
      logic wr_tag;
      logic inc_all;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: hdl/rhlc_cell.sv
// One cache slot: tag pair, recency rank, and its links in the lookup chain.
`default_nettype none
module rhlc_cell #(
   parameter int WAYS  = rhlc_pkg::DEF_WAYS,
   parameter int TAG_W = rhlc_pkg::CHUNK_W - rhlc_pkg::DEF_REGION_SHIFT,
   parameter int INDEX = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       valid,
   input  wire  [TAG_W-1:0]          look_x,
   input  wire  [TAG_W-1:0]          look_z,
   input  wire  rhlc_pkg::cell_ctl_type ctl,
   input  wire  [$clog2(WAYS)-1:0]   upd_tgt,
   input  wire  [$clog2(WAYS)-1:0]   upd_thr,
   input  wire                       lo_hit_seen,
   input  wire  [$clog2(WAYS)-1:0]   lo_hit_idx,
   input  wire  [$clog2(WAYS)-1:0]   lo_hit_rank,
   input  wire                       lo_vic_seen,
   input  wire  [$clog2(WAYS)-1:0]   lo_vic_idx,
   input  wire  [TAG_W-1:0]          lo_vic_x,
   input  wire  [TAG_W-1:0]          lo_vic_z,
   output logic                      hi_hit_seen,
   output logic [$clog2(WAYS)-1:0]   hi_hit_idx,
   output logic [$clog2(WAYS)-1:0]   hi_hit_rank,
   output logic                      hi_vic_seen,
   output logic [$clog2(WAYS)-1:0]   hi_vic_idx,
   output logic [TAG_W-1:0]          hi_vic_x,
   output logic [TAG_W-1:0]          hi_vic_z
);

   localparam int IW = $clog2(WAYS);
   localparam logic [IW-1:0] MY_IDX   = IW'(INDEX);
   localparam logic [IW-1:0] OLDEST   = IW'(WAYS - 1);

   logic [TAG_W-1:0] tag_x_ff, tag_x_in;
   logic [TAG_W-1:0] tag_z_ff, tag_z_in;
   logic [IW-1:0]    rank_ff, rank_in;
   logic             my_hit, my_sel, my_vic, is_tgt;

   // lowest matching slot wins; the oldest slot is taken as victim
   always_comb begin
      my_hit      = valid && (tag_x_ff == look_x) && (tag_z_ff == look_z);
      my_sel      = my_hit && !lo_hit_seen;
      hi_hit_seen = lo_hit_seen || my_hit;
      hi_hit_idx  = my_sel ? MY_IDX : lo_hit_idx;
      hi_hit_rank = my_sel ? rank_ff : lo_hit_rank;
      my_vic      = valid && (rank_ff == OLDEST);
      hi_vic_seen = lo_vic_seen || my_vic;
      hi_vic_idx  = my_vic ? MY_IDX : lo_vic_idx;
      hi_vic_x    = my_vic ? tag_x_ff : lo_vic_x;
      hi_vic_z    = my_vic ? tag_z_ff : lo_vic_z;
   end

   always_comb begin
      is_tgt   = (upd_tgt == MY_IDX);
      rank_in  = rank_ff;
      tag_x_in = tag_x_ff;
      tag_z_in = tag_z_ff;
      if (ctl.upd) begin
         if (is_tgt) begin
            rank_in = '0;
            if (ctl.wr_tag) begin
               tag_x_in = look_x;
               tag_z_in = look_z;
            end
         end else if (valid && (ctl.inc_all || (rank_ff < upd_thr))) begin
            rank_in = rank_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
      end else begin
         rank_ff <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_x_ff <= tag_x_in;
      tag_z_ff <= tag_z_in;
   end

endmodule
`default_nettype wire

FILE: hdl/region_handle_lru_cache_unit.sv
// Top level of the fully associative LRU cache of region tags.
// Usage:
//   Request channel (req_*): one chunk coordinate pair plus open_ok per
//   transaction, taken when req_valid is high and req_stall is low.
//   Response channel (rsp_*): exactly one response transaction per request,
//   in request order, taken when rsp_valid is high and rsp_stall is low.
//   A taken request is registered, its compare phase registers the decision
//   and its update phase loads the response register. The slots form a
//   chain of cells; the compare phase runs the tag compare and victim search
//   along the chain, the update phase broadcasts the recency update. The
//   next request can be taken in the update phase.
//   Stall: a response held by rsp_stall sits in the output register; the
//   update of the following request waits until that register frees, and
//   req_stall stays high meanwhile.
//   Reset (synchronous, active high): empties the cache (fill count and
//   ranks cleared) and drops any response in flight. Tags need no clearing:
//   slots at or above the fill count are never compared.
`default_nettype none
module region_handle_lru_cache_unit #(
   parameter int WAYS         = rhlc_pkg::DEF_WAYS,
   parameter int REGION_SHIFT = rhlc_pkg::DEF_REGION_SHIFT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  signed [rhlc_pkg::CHUNK_W-1:0]  req_chunk_x,
   input  wire  signed [rhlc_pkg::CHUNK_W-1:0]  req_chunk_z,
   input  wire                                  req_open_ok,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_found,
   output logic        [rhlc_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                                 rsp_was_hit,
   output logic                                 rsp_evicted,
   output logic signed [rhlc_pkg::EV_W-1:0]     rsp_evicted_region_x,
   output logic signed [rhlc_pkg::EV_W-1:0]     rsp_evicted_region_z
);

   localparam int TAG_W = rhlc_pkg::CHUNK_W - REGION_SHIFT;
   localparam int IW    = $clog2(WAYS);
   localparam int FW    = $clog2(WAYS + 1);
   localparam logic [FW-1:0] FULL_CNT = FW'(WAYS);
   localparam logic [IW-1:0] OLDEST   = IW'(WAYS - 1);

   // phase control
   rhlc_pkg::phase_type phase_ff, phase_in;
   logic take_req, out_free, go;

   // request held through compare and update
   logic [TAG_W-1:0] look_x_ff, look_x_in;
   logic [TAG_W-1:0] look_z_ff, look_z_in;
   logic             open_ff, open_in;
   logic signed [rhlc_pkg::CHUNK_W-1:0] shx, shz;

   // fill count
   logic [FW-1:0] filled_ff, filled_in;

   // registered decision from the compare cycle
   logic          dec_upd_ff, dec_upd_in;
   logic          dec_wr_ff, dec_wr_in;
   logic          dec_inc_ff, dec_inc_in;
   logic          dec_grow_ff, dec_grow_in;
   logic [IW-1:0] dec_tgt_ff, dec_tgt_in;
   logic [IW-1:0] dec_thr_ff, dec_thr_in;
   logic          dec_found_ff, dec_found_in;
   logic          dec_hit_ff, dec_hit_in;
   logic          dec_ev_ff, dec_ev_in;
   logic [rhlc_pkg::EV_W-1:0] dec_evx_ff, dec_evx_in;
   logic [rhlc_pkg::EV_W-1:0] dec_evz_ff, dec_evz_in;
   logic [rhlc_pkg::CHUNK_W-1:0] vic_x_wide, vic_z_wide;
   logic [7:0]    slot_wide;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_hit_ff, rsp_ev_ff;
   logic [rhlc_pkg::SLOT_W-1:0]    rsp_slot_ff;
   logic [rhlc_pkg::EV_W-1:0]      rsp_evx_ff, rsp_evz_ff;

   // cell chain links
   logic            hit_seen [WAYS+1];
   logic [IW-1:0]   hit_idx  [WAYS+1];
   logic [IW-1:0]   hit_rank [WAYS+1];
   logic            vic_seen [WAYS+1];
   logic [IW-1:0]   vic_idx  [WAYS+1];
   logic [TAG_W-1:0] vic_x   [WAYS+1];
   logic [TAG_W-1:0] vic_z   [WAYS+1];
   logic [WAYS-1:0] slot_valid;
   rhlc_pkg::cell_ctl_type cell_ctl;

   // free the output register when it is empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go        = (phase_ff == rhlc_pkg::PH_UPD) && out_free;
   assign req_stall = !((phase_ff == rhlc_pkg::PH_IDLE) || go);
   assign take_req  = req_valid && !req_stall;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         rhlc_pkg::PH_IDLE: if (take_req) phase_in = rhlc_pkg::PH_CMP;
         rhlc_pkg::PH_CMP:  phase_in = rhlc_pkg::PH_UPD;
         rhlc_pkg::PH_UPD: begin
            if (go) phase_in = take_req ? rhlc_pkg::PH_CMP : rhlc_pkg::PH_IDLE;
         end
         default:           phase_in = rhlc_pkg::PH_IDLE;
      endcase
   end

   // floor-shift the chunk coordinates into region tags on entry
   always_comb begin
      shx       = req_chunk_x >>> REGION_SHIFT;
      shz       = req_chunk_z >>> REGION_SHIFT;
      look_x_in = take_req ? shx[TAG_W-1:0] : look_x_ff;
      look_z_in = take_req ? shz[TAG_W-1:0] : look_z_ff;
      open_in   = take_req ? req_open_ok : open_ff;
   end

   // chain ends: nothing seen below slot 0
   assign hit_seen[0] = 1'b0;
   assign hit_idx[0]  = '0;
   assign hit_rank[0] = '0;
   assign vic_seen[0] = 1'b0;
   assign vic_idx[0]  = '0;
   assign vic_x[0]    = '0;
   assign vic_z[0]    = '0;

   assign cell_ctl.upd     = go && dec_upd_ff;
   assign cell_ctl.wr_tag  = dec_wr_ff;
   assign cell_ctl.inc_all = dec_inc_ff;

   for (genvar k = 0; k < WAYS; k++) begin : g_cell
      assign slot_valid[k] = (FW'(k) < filled_ff);
      rhlc_cell #(
         .WAYS  (WAYS),
         .TAG_W (TAG_W),
         .INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .valid       (slot_valid[k]),
         .look_x      (look_x_ff),
         .look_z      (look_z_ff),
         .ctl         (cell_ctl),
         .upd_tgt     (dec_tgt_ff),
         .upd_thr     (dec_thr_ff),
         .lo_hit_seen (hit_seen[k]),
         .lo_hit_idx  (hit_idx[k]),
         .lo_hit_rank (hit_rank[k]),
         .lo_vic_seen (vic_seen[k]),
         .lo_vic_idx  (vic_idx[k]),
         .lo_vic_x    (vic_x[k]),
         .lo_vic_z    (vic_z[k]),
         .hi_hit_seen (hit_seen[k+1]),
         .hi_hit_idx  (hit_idx[k+1]),
         .hi_hit_rank (hit_rank[k+1]),
         .hi_vic_seen (vic_seen[k+1]),
         .hi_vic_idx  (vic_idx[k+1]),
         .hi_vic_x    (vic_x[k+1]),
         .hi_vic_z    (vic_z[k+1])
      );
   end

   // compare cycle: decide hit, fill, evict or refused miss and hold the outcome
   always_comb begin
      vic_x_wide   = rhlc_pkg::CHUNK_W'(signed'(vic_x[WAYS]));
      vic_z_wide   = rhlc_pkg::CHUNK_W'(signed'(vic_z[WAYS]));
      dec_upd_in   = 1'b0;
      dec_wr_in    = 1'b0;
      dec_inc_in   = 1'b0;
      dec_grow_in  = 1'b0;
      dec_tgt_in   = '0;
      dec_thr_in   = '0;
      dec_found_in = 1'b0;
      dec_hit_in   = 1'b0;
      dec_ev_in    = 1'b0;
      dec_evx_in   = '0;
      dec_evz_in   = '0;
      if (hit_seen[WAYS]) begin
         dec_upd_in   = 1'b1;
         dec_tgt_in   = hit_idx[WAYS];
         dec_thr_in   = hit_rank[WAYS];
         dec_found_in = 1'b1;
         dec_hit_in   = 1'b1;
      end else if (open_ff) begin
         dec_upd_in   = 1'b1;
         dec_wr_in    = 1'b1;
         dec_found_in = 1'b1;
         if (filled_ff != FULL_CNT) begin
            // fill the next unused slot; every filled slot ages
            dec_inc_in  = 1'b1;
            dec_grow_in = 1'b1;
            dec_tgt_in  = filled_ff[IW-1:0];
         end else begin
            dec_tgt_in = vic_idx[WAYS];
            dec_thr_in = OLDEST;
            dec_ev_in  = 1'b1;
            dec_evx_in = vic_x_wide[rhlc_pkg::EV_W-1:0];
            dec_evz_in = vic_z_wide[rhlc_pkg::EV_W-1:0];
         end
      end
   end

   always_comb begin
      filled_in    = (go && dec_grow_ff) ? filled_ff + FW'(1) : filled_ff;
      rsp_valid_in = go ? 1'b1 : (rsp_valid_ff && rsp_stall);
      slot_wide    = 8'(dec_tgt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rhlc_pkg::PH_IDLE;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: request, decision and response registers
   always_ff @(posedge clock) begin
      look_x_ff <= look_x_in;
      look_z_ff <= look_z_in;
      open_ff   <= open_in;
      if (phase_ff == rhlc_pkg::PH_CMP) begin
         dec_upd_ff   <= dec_upd_in;
         dec_wr_ff    <= dec_wr_in;
         dec_inc_ff   <= dec_inc_in;
         dec_grow_ff  <= dec_grow_in;
         dec_tgt_ff   <= dec_tgt_in;
         dec_thr_ff   <= dec_thr_in;
         dec_found_ff <= dec_found_in;
         dec_hit_ff   <= dec_hit_in;
         dec_ev_ff    <= dec_ev_in;
         dec_evx_ff   <= dec_evx_in;
         dec_evz_ff   <= dec_evz_in;
      end
      if (go) begin
         rsp_found_ff <= dec_found_ff;
         rsp_slot_ff  <= dec_found_ff ? slot_wide[rhlc_pkg::SLOT_W-1:0] : '0;
         rsp_hit_ff   <= dec_hit_ff;
         rsp_ev_ff    <= dec_ev_ff;
         rsp_evx_ff   <= dec_evx_ff;
         rsp_evz_ff   <= dec_evz_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_was_hit          = rsp_hit_ff;
   assign rsp_evicted          = rsp_ev_ff;
   assign rsp_evicted_region_x = signed'(rsp_evx_ff);
   assign rsp_evicted_region_z = signed'(rsp_evz_ff);

endmodule
`default_nettype wire

FILE: hdl/rhlc_checker.sv
// Port-level checker for the region handle LRU cache, bound to the top level.
`default_nettype none
`include "region_handle_lru_cache_unit_defines.svh"
module rhlc_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_stall,
   input wire  signed [rhlc_pkg::CHUNK_W-1:0]  req_chunk_x,
   input wire  signed [rhlc_pkg::CHUNK_W-1:0]  req_chunk_z,
   input wire                                  req_open_ok,
   input wire                                  rsp_valid,
   input wire                                  rsp_stall,
   input wire                                  rsp_found,
   input wire         [rhlc_pkg::SLOT_W-1:0]   rsp_slot,
   input wire                                  rsp_was_hit,
   input wire                                  rsp_evicted,
   input wire  signed [rhlc_pkg::EV_W-1:0]     rsp_evicted_region_x,
   input wire  signed [rhlc_pkg::EV_W-1:0]     rsp_evicted_region_z
);

   logic req_take, miss_closed, rsp_held, miss_clean, hit_or_ev, flags_ok;

   assign req_take    = req_valid && !req_stall;
   assign miss_closed = rsp_valid && !rsp_found;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign miss_clean  = (rsp_slot == '0) && !rsp_was_hit && !rsp_evicted &&
                        (rsp_evicted_region_x == '0) && (rsp_evicted_region_z == '0);
   assign hit_or_ev   = rsp_valid && (rsp_was_hit || rsp_evicted);
   assign flags_ok    = rsp_found && !(rsp_was_hit && rsp_evicted);

   // hold a stalled response
   `RHLC_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid, "response dropped under stall")
   // one request in the compare cycle at a time
   `RHLC_ASSERT_NEXT(a_one_item, req_take, req_stall, "request taken during compare cycle")
   // not found: every other field zero
   `RHLC_ASSERT_SAME(a_miss_zero, miss_closed, miss_clean, "not-found response carries data")
   // a hit or an eviction is always found, never both
   `RHLC_ASSERT_SAME(a_hit_ev, hit_or_ev, flags_ok, "hit and eviction flags inconsistent")

endmodule

bind region_handle_lru_cache_unit rhlc_checker u_rhlc_checker (.*);
`default_nettype wire

FILE: sim/region_lookup_checker.sv
// Checker that predicts and compares every response of the region handle LRU cache.
`timescale 1ns / 1ps
module region_lookup_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   input  wire                             req_stall,
   input  wire  [rhlc_pkg::CHUNK_W-1:0]    req_chunk_x,
   input  wire  [rhlc_pkg::CHUNK_W-1:0]    req_chunk_z,
   input  wire                             req_open_ok,
   input  wire                             rsp_valid,
   input  wire                             rsp_stall,
   input  wire                             rsp_found,
   input  wire  [rhlc_pkg::SLOT_W-1:0]     rsp_slot,
   input  wire                             rsp_was_hit,
   input  wire                             rsp_evicted,
   input  wire  [rhlc_pkg::EV_W-1:0]       rsp_evicted_region_x,
   input  wire  [rhlc_pkg::EV_W-1:0]       rsp_evicted_region_z,
   output int                              mismatches,
   output int                              outstanding
);

   localparam int WAYS    = rhlc_pkg::DEF_WAYS;
   localparam int SHIFT   = rhlc_pkg::DEF_REGION_SHIFT;
   localparam int CHUNK_W = rhlc_pkg::CHUNK_W;
   localparam int SLOT_W  = rhlc_pkg::SLOT_W;
   localparam int EV_W    = rhlc_pkg::EV_W;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic              was_hit;
      logic              evicted;
      logic [EV_W-1:0]   ev_x;
      logic [EV_W-1:0]   ev_z;
   } lookup_result_type;

   logic signed [CHUNK_W-1:0] tag_x [WAYS];
   logic signed [CHUNK_W-1:0] tag_z [WAYS];
   int                        age_rank [WAYS];
   int                        filled;
   lookup_result_type         predicted_responses [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      filled      = 0;
   end

   // Make slot s the most recent; filled slots younger than old_rank age by one.
   function automatic void promote_slot(int s, int old_rank);
      for (int k = 0; k < filled; k++) begin
         if (k != s && age_rank[k] < old_rank) age_rank[k]++;
      end
      age_rank[s] = 0;
   endfunction

   function automatic lookup_result_type predict_lookup(logic [CHUNK_W-1:0] cx,
                                                        logic [CHUNK_W-1:0] cz,
                                                        logic ok);
      lookup_result_type         r;
      logic signed [CHUNK_W-1:0] rx;
      logic signed [CHUNK_W-1:0] rz;
      int                        hit;
      int                        victim;
      r   = '0;
      rx  = $signed(cx) >>> SHIFT;
      rz  = $signed(cz) >>> SHIFT;
      hit = -1;
      for (int k = 0; k < filled; k++) begin
         if (hit < 0 && tag_x[k] == rx && tag_z[k] == rz) hit = k;
      end
      if (hit >= 0) begin
         promote_slot(hit, age_rank[hit]);
         r.found   = 1'b1;
         r.slot    = hit[SLOT_W-1:0];
         r.was_hit = 1'b1;
         return r;
      end
      if (!ok) return r;
      if (filled < WAYS) begin
         victim = filled;
         filled++;
         tag_x[victim] = rx;
         tag_z[victim] = rz;
         promote_slot(victim, filled);
      end else begin
         victim = 0;
         for (int k = 0; k < WAYS; k++) begin
            if (age_rank[k] == WAYS - 1) victim = k;
         end
         r.evicted = 1'b1;
         r.ev_x    = tag_x[victim][EV_W-1:0];
         r.ev_z    = tag_z[victim][EV_W-1:0];
         tag_x[victim] = rx;
         tag_z[victim] = rz;
         promote_slot(victim, age_rank[victim]);
      end
      r.found = 1'b1;
      r.slot  = victim[SLOT_W-1:0];
      return r;
   endfunction

   function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 0;
      $display("%0t: response %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      int                bad;
      lookup_result_type want;
      bad = 0;
      if (reset) begin
         filled = 0;
         for (int k = 0; k < WAYS; k++) age_rank[k] = 0;
         predicted_responses.delete();
         outstanding <= 0;
      end else begin
         // take the response first: it always belongs to an older request
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (predicted_responses.size() == 0) begin
               $display("%0t: response with none expected: expected nothing, actual found=%0b",
                        $time, rsp_found);
               bad++;
            end else begin
               want = predicted_responses.pop_front();
               bad += field_differs("found", want.found, rsp_found);
               bad += field_differs("slot", want.slot, rsp_slot);
               bad += field_differs("was_hit", want.was_hit, rsp_was_hit);
               bad += field_differs("evicted", want.evicted, rsp_evicted);
               bad += field_differs("evicted_region_x", want.ev_x, rsp_evicted_region_x);
               bad += field_differs("evicted_region_z", want.ev_z, rsp_evicted_region_z);
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            predicted_responses.push_back(predict_lookup(req_chunk_x, req_chunk_z,
                                                         req_open_ok));
         mismatches  <= mismatches + bad;
         outstanding <= predicted_responses.size();
      end
   end

endmodule

FILE: sim/testbench.sv
// Top of the testbench: stimulus, response back-pressure and verdict for the region cache.
`timescale 1ns / 1ps
module testbench;

   localparam int CHUNK_W    = rhlc_pkg::CHUNK_W;
   localparam int SLOT_W     = rhlc_pkg::SLOT_W;
   localparam int EV_W       = rhlc_pkg::EV_W;
   localparam int OFF_W      = rhlc_pkg::DEF_REGION_SHIFT;
   // Region tag width at the default shift; chunk coordinates are {region, offset}.
   localparam int REGION_W   = CHUNK_W - OFF_W;
   localparam int POOL       = 16;
   localparam int CYCLE_CAP  = 1000000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic [CHUNK_W-1:0]  req_chunk_x = '0;
   logic [CHUNK_W-1:0]  req_chunk_z = '0;
   logic                req_open_ok = 1'b0;
   logic                rsp_stall   = 1'b0;
   wire                 req_stall;
   wire                 rsp_valid;
   wire                 rsp_found;
   wire  [SLOT_W-1:0]   rsp_slot;
   wire                 rsp_was_hit;
   wire                 rsp_evicted;
   wire  [EV_W-1:0]     rsp_evicted_region_x;
   wire  [EV_W-1:0]     rsp_evicted_region_z;

   int                  mismatches;
   int                  outstanding;
   int                  cycle_count = 0;
   bit                  hold_off_req = 1'b0;

   // Working set of region tags; a small pool drives hits, a large one evictions.
   logic [REGION_W-1:0] pool_x [POOL];
   logic [REGION_W-1:0] pool_z [POOL];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   region_handle_lru_cache_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_chunk_x          (req_chunk_x),
      .req_chunk_z          (req_chunk_z),
      .req_open_ok          (req_open_ok),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_slot             (rsp_slot),
      .rsp_was_hit          (rsp_was_hit),
      .rsp_evicted          (rsp_evicted),
      .rsp_evicted_region_x (rsp_evicted_region_x),
      .rsp_evicted_region_z (rsp_evicted_region_z)
   );

   region_lookup_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_chunk_x          (req_chunk_x),
      .req_chunk_z          (req_chunk_z),
      .req_open_ok          (req_open_ok),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_slot             (rsp_slot),
      .rsp_was_hit          (rsp_was_hit),
      .rsp_evicted          (rsp_evicted),
      .rsp_evicted_region_x (rsp_evicted_region_x),
      .rsp_evicted_region_z (rsp_evicted_region_z),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   // Gap length shared by sender and receiver: mostly none or short, now and then long.
   function automatic int random_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Pick a region tag: full range, the extremes and their neighbours, or near zero.
   function automatic logic [REGION_W-1:0] random_region();
      case ($urandom_range(0, 3))
         0: return REGION_W'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return {1'b1, {(REGION_W-1){1'b0}}};
               1: return {1'b0, {(REGION_W-1){1'b1}}};
               2: return {1'b1, {(REGION_W-2){1'b0}}, 1'b1};
               default: return {1'b0, {(REGION_W-2){1'b1}}, 1'b0};
            endcase
         end
         default: return REGION_W'($urandom_range(0, 12) - 6);
      endcase
   endfunction

   // Offer one lookup and hold it until the block takes it; valid stays high on return.
   task automatic send_lookup(input logic [CHUNK_W-1:0] cx, input logic [CHUNK_W-1:0] cz,
                              input logic ok);
      req_valid   <= 1'b1;
      req_chunk_x <= cx;
      req_chunk_z <= cz;
      req_open_ok <= ok;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Drop valid for a number of cycles between transactions.
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Drop valid and hold until the checker has seen every expected response.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Mostly lookups from the working set with a random chunk offset; some wholly random.
   task automatic send_random_lookup(input int pool_used);
      int                 pick;
      logic [CHUNK_W-1:0] cx;
      logic [CHUNK_W-1:0] cz;
      logic [OFF_W-1:0]   off_x;
      logic [OFF_W-1:0]   off_z;
      off_x = OFF_W'($urandom);
      off_z = OFF_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         cx = CHUNK_W'($urandom);
         cz = CHUNK_W'($urandom);
      end else begin
         pick = $urandom_range(0, pool_used - 1);
         cx   = {pool_x[pick], off_x};
         cz   = {pool_z[pick], off_z};
      end
      send_lookup(cx, cz, $urandom_range(0, 99) < 85);
   endtask

   // Receiver: random stalls, calm stretches, and a long hold-off on request.
   initial begin
      int rx_cycles;
      int stall_left;
      bit calm;
      rx_cycles  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         calm = ((rx_cycles / 256) % 4) == 3;
         if (hold_off_req) begin
            // hold off long enough for the block to fill and stall its input
            hold_off_req = 1'b0;
            stall_left   = 400;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm) stall_left = random_gap();
         end
      end
   end

   // Run limit: end the run as failed if the stimulus never completes.
   initial begin
      while (cycle_count < CYCLE_CAP) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** region_handle_lru_cache_unit: FAILED **");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: miss on an empty cache with open refused.
      send_lookup(0, 0, 1'b0);
      // Fill seven slots, starting with the coordinate extremes.
      send_lookup(-8388608, 8388607, 1'b1);
      send_lookup(8388607, -8388608, 1'b1);
      send_lookup(0, 0, 1'b1);
      send_lookup(-1, -1, 1'b1);
      send_lookup(31, -32, 1'b1);
      send_lookup(32, 1, 1'b1);
      send_lookup(-33, 64, 1'b1);
      // Miss with open refused while a slot is still free: nothing changes.
      send_lookup(100000, -100000, 1'b0);
      send_lookup(100000, -100000, 1'b1);
      // Hits, one with open refused, one at the other end of a region.
      send_lookup(5, 7, 1'b0);
      send_lookup(-8388577, 8388576, 1'b1);
      send_lookup(-32, -1, 1'b1);
      // Full cache: evict the least recent entry, first the extreme tag pair.
      send_lookup(4096, -4097, 1'b1);
      send_lookup(8388607, -8388608, 1'b0);
      send_lookup(8388607, -8388608, 1'b1);
      send_lookup(-4096, 4095, 1'b1);
      send_lookup(5, 7, 1'b1);
      send_lookup(-1, -32, 1'b1);
      send_lookup(-8388608, -8388608, 1'b1);
      send_lookup(8388607, 8388607, 1'b1);
      send_lookup(0, 0, 1'b1);
      drain_responses();

      // Random phases: the working set grows from hit-heavy to eviction-heavy.
      for (int phase = 0; phase < 5; phase++) begin
         for (int i = 0; i < POOL; i++) begin
            pool_x[i] = random_region();
            pool_z[i] = random_region();
         end
         for (int n = 0; n < 250; n++) begin
            // arm the long receiver hold-off while the sender keeps offering
            if ((phase == 2 && n == 40) || (phase == 4 && n == 120)) hold_off_req = 1'b1;
            // now and then replace an x tag and a z tag of the working set so fresh misses keep coming
            if (n % 25 == 24) begin
               pool_x[$urandom_range(0, POOL - 1)] = random_region();
               pool_z[$urandom_range(0, POOL - 1)] = random_region();
            end
            send_random_lookup(3 + 3 * phase);
            // back-to-back in phase one, random gaps elsewhere
            if (phase != 1) pause_sender(random_gap());
         end
         drain_responses();
      end

      // Let any stray response surface before the verdict.
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("** region_handle_lru_cache_unit: PASSED **");
      end else begin
         $display("** region_handle_lru_cache_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rhlc_pkg.sv
hdl/rhlc_cell.sv
hdl/region_handle_lru_cache_unit.sv
hdl/rhlc_checker.sv
sim/region_lookup_checker.sv
sim/testbench.sv
